// ----- rtl/core/trivium_keystream_generator_defines.svh -----
// Assertion macros shared by the keystream generator RTL.
`ifndef TRIVIUM_KEYSTREAM_GENERATOR_DEFINES_SVH
`define TRIVIUM_KEYSTREAM_GENERATOR_DEFINES_SVH

// Check on every clock edge outside reset.
`define TKS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define TKS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tks_pkg.sv -----
// Types and constants of the Trivium keystream generator.
`timescale 1ns / 1ps
package tks_pkg;

	localparam int LEN_A       = 93;
	localparam int LEN_B       = 84;
	localparam int LEN_C       = 111;
	localparam int LOAD_BITS   = 80;
	localparam int STEP_ROUNDS = 64;
	localparam int WORD_W      = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int HIGH_W      = 16;

	typedef struct packed {
		logic [LEN_A-1:0] a;
		logic [LEN_B-1:0] b;
		logic [LEN_C-1:0] c;
	} tks_state_t;

	typedef enum logic {
		OP_START    = 1'b0,
		OP_GENERATE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_LOW  = 3'd0,
		REG_KEY_HIGH = 3'd1,
		REG_IV_LOW   = 3'd2,
		REG_IV_HIGH  = 3'd3
	} cfg_reg_t;

endpackage

// ----- rtl/core/tks_if.sv -----
// Handshake channel interfaces: command in, result out, register writes.
`timescale 1ns / 1ps
interface tks_cmd_if import tks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [WORD_W-1:0] text_word;

	modport source (output valid, output opcode, output text_word, input ready);
	modport sink (input valid, input opcode, input text_word, output ready);
endinterface

interface tks_res_if import tks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] keystream_word;
	logic [WORD_W-1:0] masked_word;
	logic              not_ready;

	modport source (output valid, output keystream_word, output masked_word,
		output not_ready, input ready);
	modport sink (input valid, input keystream_word, input masked_word,
		input not_ready, output ready);
endinterface

interface tks_cfg_if import tks_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tks_rounds.sv -----
// Unrolled block of Trivium rounds: next state and keystream bits in one pass.
`timescale 1ns / 1ps
module tks_rounds import tks_pkg::*; #(
	parameter int ROUNDS = 64
) (
	input  tks_state_t        state_in,
	output tks_state_t        state_out,
	output logic [WORD_W-1:0] ks
);

	logic [STEP_ROUNDS-1:0] t1;
	logic [STEP_ROUNDS-1:0] t2;
	logic [STEP_ROUNDS-1:0] t3;

	// Every tap sits at position 65 or above, so within 64 rounds each
	// tap of round j reads the incoming state shifted by j.
	always_comb begin
		ks = '0;
		t1 = '0;
		t2 = '0;
		t3 = '0;
		for (int j = 0; j < ROUNDS; j++) begin
			ks[j] = state_in.a[65-j] ^ state_in.a[92-j] ^ state_in.b[68-j]
				^ state_in.b[83-j] ^ state_in.c[65-j] ^ state_in.c[110-j];
			t1[j] = state_in.a[65-j] ^ state_in.a[92-j]
				^ (state_in.a[90-j] & state_in.a[91-j]) ^ state_in.b[77-j];
			t2[j] = state_in.b[68-j] ^ state_in.b[83-j]
				^ (state_in.b[81-j] & state_in.b[82-j]) ^ state_in.c[86-j];
			t3[j] = state_in.c[65-j] ^ state_in.c[110-j]
				^ (state_in.c[108-j] & state_in.c[109-j]) ^ state_in.a[68-j];
		end
	end

	// Round j's feedback bit ends up at position ROUNDS-1-j.
	always_comb begin
		for (int i = 0; i < LEN_A; i++) begin
			if (i >= ROUNDS) begin
				state_out.a[i] = state_in.a[i-ROUNDS];
			end else begin
				state_out.a[i] = t3[ROUNDS-1-i];
			end
		end
		for (int i = 0; i < LEN_B; i++) begin
			if (i >= ROUNDS) begin
				state_out.b[i] = state_in.b[i-ROUNDS];
			end else begin
				state_out.b[i] = t1[ROUNDS-1-i];
			end
		end
		for (int i = 0; i < LEN_C; i++) begin
			if (i >= ROUNDS) begin
				state_out.c[i] = state_in.c[i-ROUNDS];
			end else begin
				state_out.c[i] = t2[ROUNDS-1-i];
			end
		end
	end

endmodule

// ----- rtl/core/tks_cfg_regs.sv -----
// Key and IV registers behind the configuration write channel.
`timescale 1ns / 1ps
module tks_cfg_regs import tks_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	tks_cfg_if.sink              cfg,
	output logic [LOAD_BITS-1:0] key,
	output logic [LOAD_BITS-1:0] iv
);

	logic [CFG_DATA_W-1:0] key_low_q;
	logic [HIGH_W-1:0]     key_high_q;
	logic [CFG_DATA_W-1:0] iv_low_q;
	logic [HIGH_W-1:0]     iv_high_q;
	logic                  cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				REG_KEY_HIGH: key_high_q <= cfg.data[HIGH_W-1:0];
				REG_IV_LOW:   iv_low_q   <= cfg.data;
				REG_IV_HIGH:  iv_high_q  <= cfg.data[HIGH_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign key = {key_high_q, key_low_q};
	assign iv  = {iv_high_q, iv_low_q};

endmodule

// ----- rtl/core/trivium_keystream_generator.sv -----
// Trivium keystream generator: 80-bit key and IV, 288-bit state.
// Channels: cmd takes requests (opcode, text_word); result returns
// keystream_word, masked_word and not_ready; cfg writes key_low, key_high,
// iv_low and iv_high at indexes 0 to 3 and is always ready.
// A start request loads key and IV, then runs the warm-up through a 64-round
// unrolled unit, with a partial block for the last step when WARMUP_ROUNDS is
// not a multiple of 64; cmd.ready is low during the warm-up. A start request returns no result.
// A generate request advances WORD_BITS rounds through its own unrolled round
// block; its result is registered and shows up on result in the cycle after
// acceptance. Generate requests are accepted every cycle while no warm-up runs
// and no result word is held, so the throughput is one word per clock.
// Generate before any start returns zero words with not_ready set.
// When the receiver stalls, the result register holds its word and cmd.ready
// drops until that word is taken; a taken word frees the slot in the same
// cycle.
// Reset clears the key and IV registers, the started flag, the warm-up
// counter and the result valid flag.
`timescale 1ns / 1ps
`include "trivium_keystream_generator_defines.svh"
module trivium_keystream_generator import tks_pkg::*; #(
	parameter int WORD_BITS     = 64,
	parameter int WARMUP_ROUNDS = 1152
) (
	input  logic      clk,
	input  logic      arst_n,
	tks_cmd_if.sink   cmd,
	tks_res_if.source result,
	tks_cfg_if.sink   cfg
);

	localparam int FULL_STEPS = WARMUP_ROUNDS / STEP_ROUNDS;
	localparam int REM_ROUNDS = WARMUP_ROUNDS % STEP_ROUNDS;
	localparam int WARM_STEPS = FULL_STEPS + ((REM_ROUNDS != 0) ? 1 : 0);
	localparam int CNT_W      = (WARM_STEPS > 0) ? $clog2(WARM_STEPS + 1) : 1;

	logic [LOAD_BITS-1:0] key;
	logic [LOAD_BITS-1:0] iv;
	tks_state_t           state_q;
	tks_state_t           load_state;
	tks_state_t           gen_state;
	tks_state_t           full_state;
	tks_state_t           rem_state;
	tks_state_t           warm_state;
	logic [WORD_W-1:0]    gen_ks;
	logic [CNT_W-1:0]     warm_left_q;
	logic                 warm_busy;
	logic                 warm_last;
	logic                 started_q;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_ks_q;
	logic [WORD_W-1:0]    out_masked_q;
	logic                 out_nr_q;
	logic                 cmd_fire;
	logic                 start_fire;
	logic                 gen_fire;

	tks_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key),
		.iv     (iv)
	);

	tks_rounds #(.ROUNDS(WORD_BITS)) u_gen (
		.state_in  (state_q),
		.state_out (gen_state),
		.ks        (gen_ks)
	);

	tks_rounds #(.ROUNDS(STEP_ROUNDS)) u_warm (
		.state_in  (state_q),
		.state_out (full_state),
		.ks        ()
	);

	tks_rounds #(.ROUNDS(REM_ROUNDS)) u_rem (
		.state_in  (state_q),
		.state_out (rem_state),
		.ks        ()
	);

	assign load_state.a = {{(LEN_A-LOAD_BITS){1'b0}}, key};
	assign load_state.b = {{(LEN_B-LOAD_BITS){1'b0}}, iv};
	assign load_state.c = {3'b111, {(LEN_C-3){1'b0}}};

	assign warm_busy  = (warm_left_q != '0);
	assign warm_last  = (warm_left_q == CNT_W'(1));
	// finish the warm-up with the partial block when the count is not a multiple of 64
	assign warm_state = (warm_last && (REM_ROUNDS != 0)) ? rem_state : full_state;

	assign cmd.ready  = !warm_busy && (!out_valid_q || result.ready);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign start_fire = cmd_fire && (cmd.opcode == OP_START);
	assign gen_fire   = cmd_fire && (cmd.opcode == OP_GENERATE);

	always_ff @(posedge clk) begin
		if (start_fire) begin
			state_q <= load_state;
		end else if (warm_busy) begin
			state_q <= warm_state;
		end else if (gen_fire && started_q) begin
			state_q <= gen_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			warm_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_fire) begin
				started_q   <= 1'b1;
				warm_left_q <= CNT_W'(WARM_STEPS);
			end else if (warm_busy) begin
				warm_left_q <= warm_left_q - CNT_W'(1);
			end
			if (gen_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			if (started_q) begin
				out_ks_q     <= gen_ks;
				out_masked_q <= cmd.text_word ^ gen_ks;
				out_nr_q     <= 1'b0;
			end else begin
				out_ks_q     <= '0;
				out_masked_q <= '0;
				out_nr_q     <= 1'b1;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.keystream_word = out_ks_q;
	assign result.masked_word    = out_masked_q;
	assign result.not_ready      = out_nr_q;

	`TKS_ASSERT_ALWAYS(a_rst_no_result, !arst_n |-> !result.valid, "result valid in reset")
	`TKS_ASSERT(a_start_warms, (start_fire && (WARM_STEPS != 0)) |=> warm_busy, "no warm-up after start")
	`TKS_ASSERT(a_started_holds, started_q |=> started_q, "started flag dropped")
	`TKS_ASSERT(a_gen_result, (gen_fire && started_q) |=> (result.valid && !result.not_ready), "generate lost")
	`TKS_ASSERT(a_nr_zero, (result.valid && result.not_ready) |-> ((result.keystream_word == '0) && (result.masked_word == '0)), "not-ready word nonzero")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Trivium keystream generator with its own cipher predictor.
`timescale 1ns / 1ps
module tb_top;
	import tks_pkg::*;

	localparam int WORD_BITS          = 64;
	localparam int WARMUP_ROUNDS      = 1152;
	localparam int IDLE_PERCENT       = 11;
	localparam int TOTAL_REQUESTS     = 1900;
	localparam int RESULT_HOLD_CYCLES = 90;
	localparam int DRAIN_CYCLES       = 40;
	localparam int WATCHDOG_LIMIT     = 3000;

	typedef struct {
		bit [WORD_W-1:0] keystream_word;
		bit [WORD_W-1:0] masked_word;
		bit              not_ready;
	} word_result_t;

	logic clk;
	logic arst_n;

	tks_cmd_if cmd ();
	tks_res_if result ();
	tks_cfg_if cfg ();

	trivium_keystream_generator #(
		.WORD_BITS    (WORD_BITS),
		.WARMUP_ROUNDS(WARMUP_ROUNDS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.result(result),
		.cfg   (cfg)
	);

	// cipher state and register shadows of the predictor
	bit [LEN_A-1:0]      reg_a;
	bit [LEN_B-1:0]      reg_b;
	bit [LEN_C-1:0]      reg_c;
	bit                  cipher_started;
	bit [CFG_DATA_W-1:0] key_low_shadow;
	bit [HIGH_W-1:0]     key_high_shadow;
	bit [CFG_DATA_W-1:0] iv_low_shadow;
	bit [HIGH_W-1:0]     iv_high_shadow;

	word_result_t pending_words[$];

	int  mismatches;
	int  requests_sent;
	int  starts_sent;
	int  words_checked;
	int  register_writes;
	int  hold_asked;
	int  quiet_cycles;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one cipher round; returns the keystream bit
	function automatic bit trivium_round();
		bit t1, t2, t3, z;
		t1 = reg_a[65] ^ reg_a[92];
		t2 = reg_b[68] ^ reg_b[83];
		t3 = reg_c[65] ^ reg_c[110];
		z  = t1 ^ t2 ^ t3;
		t1 = t1 ^ (reg_a[90] & reg_a[91]) ^ reg_b[77];
		t2 = t2 ^ (reg_b[81] & reg_b[82]) ^ reg_c[86];
		t3 = t3 ^ (reg_c[108] & reg_c[109]) ^ reg_a[68];
		reg_a = {reg_a[LEN_A-2:0], t3};
		reg_b = {reg_b[LEN_B-2:0], t1};
		reg_c = {reg_c[LEN_C-2:0], t2};
		return z;
	endfunction

	function automatic void predict_request(opcode_t op, bit [WORD_W-1:0] text);
		word_result_t w;
		w.keystream_word = '0;
		w.masked_word    = '0;
		w.not_ready      = 1'b0;
		if (op == OP_START) begin
			reg_a = '0;
			reg_b = '0;
			reg_c = '0;
			reg_a[LOAD_BITS-1:0] = {key_high_shadow, key_low_shadow};
			reg_b[LOAD_BITS-1:0] = {iv_high_shadow, iv_low_shadow};
			reg_c[LEN_C-1 -: 3]  = 3'b111;
			repeat (WARMUP_ROUNDS) void'(trivium_round());
			cipher_started = 1'b1;
			starts_sent++;
			return;
		end
		if (!cipher_started) begin
			w.not_ready = 1'b1;
		end else begin
			for (int i = 0; i < WORD_BITS; i++)
				w.keystream_word[i] = trivium_round();
			w.masked_word = text ^ w.keystream_word;
		end
		pending_words.push_back(w);
	endfunction

	function automatic bit [WORD_W-1:0] random_word64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly random, sometimes all zeros or all ones
	function automatic bit [LOAD_BITS-1:0] pick_load_value();
		int pick;
		pick = $urandom_range(7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return LOAD_BITS'({$urandom(), $urandom(), $urandom()});
	endfunction

	task automatic send_request(opcode_t op, bit [WORD_W-1:0] text);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.opcode    <= op;
		cmd.text_word <= text;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		predict_request(op, text);
		requests_sent++;
	endtask

	// drop valid, wait out every result, then let any warm-up finish
	task automatic drain_words();
		cmd.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		case (index)
			REG_KEY_LOW:  key_low_shadow  = data;
			REG_KEY_HIGH: key_high_shadow = data[HIGH_W-1:0];
			REG_IV_LOW:   iv_low_shadow   = data;
			REG_IV_HIGH:  iv_high_shadow  = data[HIGH_W-1:0];
			default: ;
		endcase
		register_writes++;
	endtask

	// junk fills the unused upper bits of the high registers and adds a stray index
	task automatic load_key_iv(bit [LOAD_BITS-1:0] key, bit [LOAD_BITS-1:0] iv, bit junk);
		bit [CFG_DATA_W-HIGH_W-1:0] upper;
		upper = junk ? (CFG_DATA_W-HIGH_W)'(random_word64()) : '0;
		write_register(REG_KEY_LOW, key[CFG_DATA_W-1:0]);
		write_register(REG_KEY_HIGH, {upper, key[LOAD_BITS-1:CFG_DATA_W]});
		write_register(REG_IV_LOW, iv[CFG_DATA_W-1:0]);
		write_register(REG_IV_HIGH, {~upper, iv[LOAD_BITS-1:CFG_DATA_W]});
		if (junk)
			write_register(CFG_INDEX_W'(REG_IV_HIGH + 1 + $urandom_range(3)), random_word64());
		cfg.valid <= 1'b0;
	endtask

	task automatic test_generate_before_start();
		send_request(OP_GENERATE, '0);
		send_request(OP_GENERATE, '1);
		send_request(OP_GENERATE, random_word64());
		drain_words();
	endtask

	task automatic test_zero_key();
		load_key_iv('0, '0, 1'b0);
		send_request(OP_START, '1);
		send_request(OP_GENERATE, '0);
		send_request(OP_GENERATE, '1);
		send_request(OP_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_GENERATE, 64'h5555_5555_5555_5555);
		drain_words();
	endtask

	task automatic test_key_extremes();
		load_key_iv('1, '1, 1'b1);
		send_request(OP_START, '0);
		send_request(OP_GENERATE, '0);
		send_request(OP_GENERATE, '1);
		send_request(OP_GENERATE, 64'h8000_0000_0000_0001);
		drain_words();
		load_key_iv('1, '0, 1'b1);
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		drain_words();
		load_key_iv('0, '1, 1'b0);
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		drain_words();
	endtask

	task automatic test_repeated_start();
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		send_request(OP_GENERATE, random_word64());
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		drain_words();
	endtask

	task automatic test_full_rate();
		load_key_iv(pick_load_value(), pick_load_value(), 1'b0);
		calm = 1'b1;
		send_request(OP_START, random_word64());
		repeat (200) send_request(OP_GENERATE, random_word64());
		calm = 1'b0;
		drain_words();
	endtask

	task automatic test_result_backpressure();
		send_request(OP_START, random_word64());
		send_request(OP_GENERATE, random_word64());
		hold_asked++;
		repeat (40) send_request(OP_GENERATE, random_word64());
		drain_words();
	endtask

	task automatic test_random_traffic();
		int burst;
		while (requests_sent < TOTAL_REQUESTS) begin
			drain_words();
			calm = ($urandom_range(5) == 0);
			if ($urandom_range(4) != 0)
				load_key_iv(pick_load_value(), pick_load_value(), 1'($urandom_range(1)));
			send_request(OP_START, random_word64());
			burst = $urandom_range(5, 60);
			repeat (burst) begin
				if ($urandom_range(39) == 0)
					send_request(OP_START, random_word64());
				else
					send_request(OP_GENERATE, random_word64());
			end
			if ($urandom_range(9) == 0)
				hold_asked++;
		end
		calm = 1'b0;
		drain_words();
	endtask

	// result sink: random stalls, plus long holds on request
	initial begin : result_sink
		int hold_done;
		hold_done = 0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				hold_done++;
				result.ready <= 1'b0;
				repeat (RESULT_HOLD_CYCLES) @(posedge clk);
			end
			result.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		word_result_t want;
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result: keystream_word %h not_ready %b",
					result.keystream_word, result.not_ready);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (result.keystream_word !== want.keystream_word) begin
					$error("keystream_word: expected %h, got %h",
						want.keystream_word, result.keystream_word);
					mismatches++;
				end
				if (result.masked_word !== want.masked_word) begin
					$error("masked_word: expected %h, got %h",
						want.masked_word, result.masked_word);
					mismatches++;
				end
				if (result.not_ready !== want.not_ready) begin
					$error("not_ready: expected %b, got %b", want.not_ready, result.not_ready);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid === 1'b1 && cmd.ready === 1'b1)
			|| (result.valid === 1'b1 && result.ready === 1'b1)
			|| (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b1;
		cmd.valid       = 1'b0;
		cmd.opcode      = OP_START;
		cmd.text_word   = '0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_KEY_LOW;
		cfg.data        = '0;
		reg_a           = '0;
		reg_b           = '0;
		reg_c           = '0;
		cipher_started  = 1'b0;
		key_low_shadow  = '0;
		key_high_shadow = '0;
		iv_low_shadow   = '0;
		iv_high_shadow  = '0;
		mismatches      = 0;
		requests_sent   = 0;
		starts_sent     = 0;
		words_checked   = 0;
		register_writes = 0;
		hold_asked      = 0;
		quiet_cycles    = 0;
		calm            = 1'b0;
		// give the reset a clean falling edge ahead of the first clock edge
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_generate_before_start();
		test_zero_key();
		test_key_extremes();
		test_repeated_start();
		test_full_rate();
		test_result_backpressure();
		test_random_traffic();

		$display("covered %0d requests (%0d starts), %0d result words checked",
			requests_sent, starts_sent, words_checked);
		$display("%0d register writes incl. stray indexes; %0d long result holds",
			register_writes, hold_asked);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
